// ===== src/rspr_pkg.sv =====
// Shared types and constants for the render span position resolver.
package rspr_pkg;

  localparam int FrameW = 64;
  localparam int EpochW = 32;

  // Function codes of an input item.
  localparam logic FUNC_PUBLISH = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  // One stored span.
  typedef struct packed {
    logic [FrameW-1:0] out_begin;
    logic [FrameW-1:0] out_end;
    logic [FrameW-1:0] src_begin;
    logic [FrameW-1:0] src_end;
    logic [EpochW-1:0] epoch;
  } span_t;

  // Request from the walk controller to the arithmetic unit.
  typedef struct packed {
    logic              start;
    logic [FrameW-1:0] offset;
    logic [FrameW-1:0] src_len;
    logic [FrameW-1:0] out_len;
    logic [FrameW-1:0] src_begin;
    logic [FrameW-1:0] modulus;
  } calc_req_t;

  // Answer of the arithmetic unit.
  typedef struct packed {
    logic              done;
    logic              ok;
    logic [FrameW-1:0] value;
  } calc_rsp_t;

endpackage

// ===== src/rspr_if.sv =====
// Valid/ready channel interfaces for the resolver's input and result items.
interface rspr_in_if import rspr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [FrameW-1:0] span_output_begin;
  logic [FrameW-1:0] span_output_end;
  logic [FrameW-1:0] span_source_begin;
  logic [FrameW-1:0] span_source_end;
  logic [EpochW-1:0] span_epoch;
  logic [FrameW-1:0] query_output_frame;
  logic [EpochW-1:0] query_epoch;
  logic [FrameW-1:0] source_length;

  modport source (output valid, func, span_output_begin, span_output_end,
                  span_source_begin, span_source_end, span_epoch,
                  query_output_frame, query_epoch, source_length,
                  input ready);
  modport sink (input valid, func, span_output_begin, span_output_end,
                span_source_begin, span_source_end, span_epoch,
                query_output_frame, query_epoch, source_length,
                output ready);
endinterface

interface rspr_out_if import rspr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              resolved;
  logic [FrameW-1:0] wrapped_frame;

  modport source (output valid, resolved, wrapped_frame, input ready);
  modport sink (input valid, resolved, wrapped_frame, output ready);
endinterface

// ===== src/rspr_calc.sv =====
// Bit-serial scale and wrap unit: (begin + floor(off*num/den)) mod modulus.
module rspr_calc import rspr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  calc_req_t req,
  output calc_rsp_t rsp
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CHK, S_DIV, S_SUM, S_MOD} state_t;

  state_t              state_r;
  logic [6:0]          cnt_r;
  logic [2*FrameW-1:0] prod_r;
  logic [FrameW-1:0]   mcand_r, mplier_r, den_r, sb_r, modv_r, quo_r;
  logic [FrameW-1:0]   rem_r;
  logic [FrameW:0]     sum_r;
  logic                done_r, ok_r;
  logic [FrameW-1:0]   val_r;

  logic [2*FrameW-1:0] prod_add;
  logic [FrameW:0]     rem_sh;
  logic                take;
  logic [FrameW:0]     sum_nxt;
  logic [FrameW:0]     mod_sh;

  // Shift-and-add product step, one restoring divide step, one mod step.
  always_comb begin
    prod_add = prod_r + ({{FrameW{1'b0}}, mcand_r} << cnt_r[5:0]);
    rem_sh   = {rem_r, prod_r[2*FrameW-1]};
    take     = rem_sh >= {1'b0, den_r};
    sum_nxt  = {1'b0, sb_r} + {1'b0, quo_r};
    mod_sh   = {1'b0, modv_r} << cnt_r[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            mcand_r  <= req.offset;
            mplier_r <= req.src_len;
            den_r    <= req.out_len;
            sb_r     <= req.src_begin;
            modv_r   <= req.modulus;
            prod_r   <= '0;
            cnt_r    <= '0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier_r[cnt_r[5:0]]) prod_r <= prod_add;
          if (cnt_r == 7'(FrameW - 1)) state_r <= S_CHK;
          cnt_r <= cnt_r + 7'd1;
        end
        S_CHK: begin
          // Quotient fits in 64 bits only when the high half is below den.
          if (prod_r[2*FrameW-1:FrameW] >= den_r) begin
            ok_r    <= 1'b0;
            val_r   <= '0;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            rem_r   <= prod_r[2*FrameW-1:FrameW];
            prod_r  <= {prod_r[FrameW-1:0], {FrameW{1'b0}}};
            quo_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= take ? FrameW'(rem_sh - {1'b0, den_r}) : rem_sh[FrameW-1:0];
          quo_r  <= {quo_r[FrameW-2:0], take};
          prod_r <= {prod_r[2*FrameW-2:0], 1'b0};
          if (cnt_r == 7'(FrameW - 1)) state_r <= S_SUM;
          cnt_r <= cnt_r + 7'd1;
        end
        S_SUM: begin
          if (sum_nxt[FrameW]) begin
            ok_r    <= 1'b0;
            val_r   <= '0;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            sum_r   <= sum_nxt;
            cnt_r   <= 7'(FrameW - 1);
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          // Subtract modulus shifted down from bit 63 to bit 0.
          if (mod_sh[FrameW] || (mod_sh >> cnt_r[5:0]) != {1'b0, modv_r}) begin
            // Shifted modulus lost bits: skip this position.
          end else if (sum_r >= mod_sh) begin
            sum_r <= sum_r - mod_sh;
          end
          if (cnt_r == '0) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
            ok_r    <= 1'b1;
            val_r   <= (sum_r >= mod_sh && !mod_sh[FrameW] &&
                        (mod_sh >> cnt_r[5:0]) == {1'b0, modv_r})
                       ? FrameW'(sum_r - mod_sh) : sum_r[FrameW-1:0];
          end
          cnt_r <= cnt_r - 7'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done_r, ok: ok_r, value: val_r};

endmodule

// ===== src/render_span_position_resolver.sv =====
// Top level of the render span position resolver.
//
// Input channel in_*: each item either publishes a span (func 0) into the
// oldest of SPAN_SLOTS ring slots, or resolves a query frame (func 1).
// A publish gives no result item; a resolve gives exactly one on out_*.
// Spans live in one synchronous memory read one slot per cycle, newest first.
// A resolve walks one slot at a time through a read state and a check
// state; a matching span then goes through the bit-serial multiply, divide
// and wrap. A miss walks every filled slot; a zero length or an empty
// ring skips the walk; an overflow ends the calculation sooner. The result
// then passes through a hold state and a pending register to the output.
// One item is in work at a time; in_ready is low while one is busy, and the
// next item can be accepted in the same cycle as the result is offered.
// The result waits in an output register while the receiver stalls; the
// next item is accepted meanwhile, and its result waits for the first to go.
// Reset empties the ring (fill count zero); memory contents are not cleared.
module render_span_position_resolver import rspr_pkg::*; #(
  parameter int SPAN_SLOTS = 16
) (
  input logic  clk,
  input logic  rst_n,
  rspr_in_if.sink    in_ch,
  rspr_out_if.source out_ch
);

  localparam int IdxW = (SPAN_SLOTS > 1) ? $clog2(SPAN_SLOTS) : 1;
  localparam int CntW = $clog2(SPAN_SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_CALC, S_HOLD} state_t;

  span_t               mem [SPAN_SLOTS];
  span_t               rd_r;
  logic [IdxW-1:0]     next_slot_r, rd_idx_r;
  logic [CntW-1:0]     filled_r, walk_r;
  state_t              state_r;
  logic [FrameW-1:0]   frame_r, len_r;
  logic [EpochW-1:0]   epoch_r;
  logic                wr_en;
  span_t               wr_data;
  logic                res_pend_r, res_ok_r;
  logic [FrameW-1:0]   res_val_r;
  logic                out_valid_r, out_res_r;
  logic [FrameW-1:0]   out_frame_r;
  calc_req_t           req;
  calc_rsp_t           rsp;
  logic                match;

  // Span memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[next_slot_r] <= wr_data;
    rd_r <= mem[rd_idx_r];
  end

  assign in_ch.ready = (state_r == S_IDLE) && !res_pend_r;
  assign wr_en = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_PUBLISH);
  assign wr_data = '{out_begin: in_ch.span_output_begin,
                     out_end: in_ch.span_output_end,
                     src_begin: in_ch.span_source_begin,
                     src_end: in_ch.span_source_end,
                     epoch: in_ch.span_epoch};

  // Qualify the span read in this cycle.
  always_comb begin
    match = (rd_r.epoch == epoch_r) && (rd_r.out_end > rd_r.out_begin) &&
            (rd_r.src_end >= rd_r.src_begin) && (frame_r >= rd_r.out_begin) &&
            (frame_r < rd_r.out_end);
    req = '{start: (state_r == S_CHECK) && match,
            offset: frame_r - rd_r.out_begin,
            src_len: rd_r.src_end - rd_r.src_begin,
            out_len: rd_r.out_end - rd_r.out_begin,
            src_begin: rd_r.src_begin,
            modulus: len_r};
  end

  rspr_calc u_calc (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // Walk controller and result staging.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_slot_r <= '0;
      filled_r    <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_pend_r && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_ok_r;
        out_frame_r <= res_val_r;
        res_pend_r  <= 1'b0;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.func == FUNC_PUBLISH) begin
              next_slot_r <= (next_slot_r == IdxW'(SPAN_SLOTS - 1)) ? '0
                             : next_slot_r + IdxW'(1);
              if (filled_r != CntW'(SPAN_SLOTS)) filled_r <= filled_r + CntW'(1);
            end else begin
              frame_r <= in_ch.query_output_frame;
              epoch_r <= in_ch.query_epoch;
              len_r   <= in_ch.source_length;
              walk_r  <= '0;
              rd_idx_r <= (next_slot_r == '0) ? IdxW'(SPAN_SLOTS - 1)
                          : next_slot_r - IdxW'(1);
              if (in_ch.source_length == '0 || filled_r == '0) begin
                res_ok_r  <= 1'b0;
                res_val_r <= '0;
                state_r   <= S_HOLD;
              end else begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          if (match) begin
            state_r <= S_CALC;
          end else if (walk_r + CntW'(1) >= filled_r) begin
            res_ok_r  <= 1'b0;
            res_val_r <= '0;
            state_r   <= S_HOLD;
          end else begin
            walk_r   <= walk_r + CntW'(1);
            rd_idx_r <= (rd_idx_r == '0) ? IdxW'(SPAN_SLOTS - 1) : rd_idx_r - IdxW'(1);
            state_r  <= S_READ;
          end
        end
        S_CALC: begin
          if (rsp.done) begin
            res_ok_r  <= rsp.ok;
            res_val_r <= rsp.value;
            state_r   <= S_HOLD;
          end
        end
        S_HOLD: begin
          res_pend_r <= 1'b1;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.resolved      = out_res_r;
  assign out_ch.wrapped_frame = out_frame_r;

endmodule

// ===== tb/sv/tb_render_span_position_resolver.sv =====
// Testbench for the render span position resolver: directed and random publish and resolve items.
module tb_render_span_position_resolver;
  import rspr_pkg::*;

  localparam int Slots = 16;
  localparam int IdleLimit = 20000;

  // One input item as the driver applies it.
  typedef struct {
    logic              func;
    logic [FrameW-1:0] ob, oe, sb, se;
    logic [EpochW-1:0] ep;
    logic [FrameW-1:0] frame;
    logic [EpochW-1:0] qep;
    logic [FrameW-1:0] len;
    bit                hold;
  } req_t;

  // One expected result item.
  typedef struct {
    logic              resolved;
    logic [FrameW-1:0] frame;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rspr_in_if  in_ch ();
  rspr_out_if out_ch ();

  render_span_position_resolver #(.SPAN_SLOTS(Slots)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  req_t    pending_items[$];
  answer_t expected_answers[$];
  bit      failed = 1'b0;
  bit      stim_done = 1'b0;
  int      idle_cycles = 0;
  int      ring_used = 0;

  // Predictor copy of the span ring.
  span_t ring[Slots];
  int    ring_next = 0;
  int    ring_fill = 0;

  // Resolves a query frame against the predicted ring.
  function automatic answer_t resolve_frame(logic [FrameW-1:0] frame,
                                            logic [EpochW-1:0] qep,
                                            logic [FrameW-1:0] len);
    answer_t    a;
    span_t      s;
    int         idx;
    logic [127:0] prod;
    logic [127:0] q;
    logic [64:0]  sum;
    a.resolved = 1'b0;
    a.frame = '0;
    if (len == 0) return a;
    for (int k = 0; k < ring_fill; k++) begin
      idx = (ring_next + Slots - 1 - k) % Slots;
      s = ring[idx];
      if (s.epoch != qep || s.out_end <= s.out_begin || s.src_end < s.src_begin ||
          frame < s.out_begin || frame >= s.out_end) continue;
      prod = 128'(frame - s.out_begin) * 128'(s.src_end - s.src_begin);
      q = prod / 128'(s.out_end - s.out_begin);
      if (q[127:64] != 0) return a;
      sum = 65'(s.src_begin) + 65'(q[63:0]);
      if (sum[64]) return a;
      a.resolved = 1'b1;
      a.frame = sum[63:0] % len;
      return a;
    end
    return a;
  endfunction

  // Applies one accepted item to the predictor.
  function automatic void predict_item(req_t r);
    if (r.func == FUNC_PUBLISH) begin
      ring[ring_next] = '{out_begin: r.ob, out_end: r.oe, src_begin: r.sb,
                         src_end: r.se, epoch: r.ep};
      ring_next = (ring_next + 1) % Slots;
      if (ring_fill < Slots) ring_fill++;
    end else begin
      expected_answers.push_back(resolve_frame(r.frame, r.qep, r.len));
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A 64-bit value biased toward edges.
  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      3: return ~(64'(1) << $urandom_range(0, 63));
      4: return 64'($urandom_range(0, 100));
      default: return rand64();
    endcase
  endfunction

  function automatic req_t publish_item(logic [63:0] ob, logic [63:0] oe, logic [63:0] sb,
                                        logic [63:0] se, logic [31:0] ep);
    req_t r;
    r.func = FUNC_PUBLISH;
    r.ob = ob; r.oe = oe; r.sb = sb; r.se = se; r.ep = ep;
    r.frame = rand64(); r.qep = $urandom(); r.len = rand64();
    r.hold = 1'b0;
    return r;
  endfunction

  function automatic req_t resolve_item(logic [63:0] frame, logic [31:0] qep,
                                        logic [63:0] len);
    req_t r;
    r.func = FUNC_RESOLVE;
    r.ob = rand64(); r.oe = rand64(); r.sb = rand64(); r.se = rand64(); r.ep = $urandom();
    r.frame = frame; r.qep = qep; r.len = len;
    r.hold = 1'b0;
    return r;
  endfunction

  // Stimulus: directed cases, then random publishes, mostly of well-formed spans, and random queries.
  initial begin
    req_t        r;
    logic [63:0] ob, olen, sb, slen, frame;
    logic [31:0] ep;
    // Empty ring, then zero length.
    pending_items.push_back(resolve_item(0, 0, 1));
    pending_items.push_back(resolve_item('1, '1, '1));
    pending_items.push_back(publish_item(100, 200, 1000, 1100, 7));
    pending_items.push_back(resolve_item(150, 7, 0));
    pending_items.push_back(resolve_item(150, 7, 64'd37));
    pending_items.push_back(resolve_item(100, 7, '1));
    pending_items.push_back(resolve_item(199, 7, '1));
    pending_items.push_back(resolve_item(200, 7, '1));
    pending_items.push_back(resolve_item(99, 7, '1));
    pending_items.push_back(resolve_item(150, 8, '1));
    // Empty output range and reversed source range never match.
    pending_items.push_back(publish_item(300, 300, 0, 10, 7));
    pending_items.push_back(publish_item(300, 400, 10, 5, 7));
    pending_items.push_back(resolve_item(300, 7, '1));
    // The newest matching span wins over an older good span.
    pending_items.push_back(publish_item(0, 10, 0, 10, 9));
    pending_items.push_back(publish_item(0, 10, '1, '1, 9));
    pending_items.push_back(resolve_item(5, 9, '1));
    // Products beyond 64 bits whose scaled offset still fits in 64 bits.
    pending_items.push_back(publish_item(0, '1, 0, '1, 3));
    pending_items.push_back(publish_item(0, 2, 0, '1, 3));
    pending_items.push_back(resolve_item(1, 3, '1));
    pending_items.push_back(resolve_item(64'hFFFF_FFFF_FFFF_FFFE, 3, '1));
    pending_items.push_back(publish_item(0, '1, '1, '1, '1));
    pending_items.push_back(resolve_item(64'hFFFF_FFFF_FFFF_FFFE, '1, 64'd1));
    r = resolve_item(50, 9, 3);
    r.hold = 1'b1;
    pending_items.push_back(r);
    // Random part.
    for (int i = 0; i < 1230; i++) begin
      ep = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) ep = $urandom();
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          pending_items.push_back(publish_item(edge64(), edge64(), edge64(), edge64(), ep));
        end else begin
          ob = ($urandom_range(0, 3) == 0) ? edge64() : 64'($urandom_range(0, 5000));
          olen = ($urandom_range(0, 3) == 0) ? edge64() : 64'($urandom_range(1, 1000));
          sb = ($urandom_range(0, 3) == 0) ? edge64() : rand64() >> $urandom_range(0, 63);
          slen = ($urandom_range(0, 3) == 0) ? edge64() : 64'($urandom_range(0, 100000));
          if (olen == 0) olen = 1;
          if (ob + olen < ob) ob = ~olen;
          if (sb + slen < sb) slen = ~sb;
          pending_items.push_back(publish_item(ob, ob + olen, sb, sb + slen, ep));
        end
      end else begin
        if (ring_used < 0) ring_used = 0;
        frame = ($urandom_range(0, 4) == 0) ? edge64() : 64'($urandom_range(0, 6000));
        r = resolve_item(frame, ep, ($urandom_range(0, 2) == 0) ? edge64()
                                                                  : 64'($urandom_range(1, 70000)));
        if ($urandom_range(0, 150) == 0) r.hold = 1'b1;
        pending_items.push_back(r);
      end
    end
    stim_done = 1'b1;
  end

  // Driver: applies items at the falling edge with random gaps.
  initial begin
    req_t r;
    int   gap;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PUBLISH;
    in_ch.span_output_begin = '0;
    in_ch.span_output_end = '0;
    in_ch.span_source_begin = '0;
    in_ch.span_source_end = '0;
    in_ch.span_epoch = '0;
    in_ch.query_output_frame = '0;
    in_ch.query_epoch = '0;
    in_ch.source_length = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    wait (stim_done);
    while (pending_items.size() > 0) begin
      r = pending_items.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (r.hold) begin
        // Let every outstanding result drain before going on.
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_answers.size() > 0) @(negedge clk);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.func <= r.func;
      in_ch.span_output_begin <= r.ob;
      in_ch.span_output_end <= r.oe;
      in_ch.span_source_begin <= r.sb;
      in_ch.span_source_end <= r.se;
      in_ch.span_epoch <= r.ep;
      in_ch.query_output_frame <= r.frame;
      in_ch.query_epoch <= r.qep;
      in_ch.source_length <= r.len;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      predict_item(r);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    // Drain, then allow for the block's latency.
    while (expected_answers.size() > 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (!failed && expected_answers.size() == 0) begin
      $display("render_span_position_resolver test passed");
    end else begin
      $display("render_span_position_resolver test failed");
    end
    $finish;
  end

  // Receiver stalls: a fresh wait is drawn after each result item.
  int stall_left = 0;
  int results_seen = 0;
  int stall_mark = 0;
  always @(negedge clk) begin
    int wait_n;
    if (results_seen != stall_mark) begin
      stall_mark <= results_seen;
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
      out_ch.ready <= (wait_n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: checks each result item against the oldest expectation.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_answers.size() == 0) begin
        $error("result item with no expectation waiting");
        failed <= 1'b1;
      end else begin
        a = expected_answers.pop_front();
        if (out_ch.resolved !== a.resolved) begin
          $error("resolved: expected %0d, actual %0d", a.resolved, out_ch.resolved);
          failed <= 1'b1;
        end
        if (out_ch.wrapped_frame !== a.frame) begin
          $error("wrapped_frame: expected %0h, actual %0h", a.frame, out_ch.wrapped_frame);
          failed <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("render_span_position_resolver test failed");
        $finish;
      end
    end
  end

endmodule

// ===== render_span_position_resolver.f =====
src/rspr_pkg.sv
src/rspr_if.sv
src/rspr_calc.sv
src/render_span_position_resolver.sv
tb/sv/tb_render_span_position_resolver.sv
